FILE: rtl/core/int8_vector_l2_normalizer_top_defines.svh
// assertion macros for the l2 normalizer
`ifndef INT8_VECTOR_L2_NORMALIZER_TOP_DEFINES_SVH
`define INT8_VECTOR_L2_NORMALIZER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define L2N_ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("l2n check failed");
`define L2N_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("l2n check failed");
`else
`define L2N_ASSERT_IMPL(label, clk, rstn, prop)
`define L2N_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

FILE: rtl/core/l2n_pkg.sv
// shared types and constants for the l2 normalizer
`timescale 1ns / 1ps
`default_nettype none
package l2n_pkg;
    localparam int ELEM_W = 8;
    localparam int NORM_W = 16;
    localparam int SUM_W  = 24;
    localparam int QMAG_W = 16;
    localparam logic [QMAG_W-1:0] QMAX = 16'd32767;
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } lane_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/core/int8_vector_l2_normalizer_top.sv
// l2 normalizer top level: load, sum of squares, lane array and output
// Usage:
// the s_ channel takes one 8-element word per request, s_in_last ends a vector.
// words are stored and their squares summed, one request per cycle while loading.
// after the last word the block emits one m_ request per stored word, each
// scaled to unit length in Q1.15; m_out_last marks the final one.
// an all-zero vector gives zero outputs with m_norm_valid low.
// words beyond MAX_WORDS are dropped but a last word still ends the vector.
// for each output word the store is read, then eight lanes run a 16-step
// bit-serial root search, each bit tried by square, multiply and compare in
// turn, then the lanes signal done and the result is loaded into the output
// register. a zero vector skips the search. s_ready stays low from the last
// input word until the last result is loaded into the output register.
// synchronous active-low reset clears sum, count, state, the wait flag and m_valid.
// when m_ready is low the result holds in the output register and the
// lanes wait for it before the next word.
`timescale 1ns / 1ps
`default_nettype none
`include "int8_vector_l2_normalizer_top_defines.svh"
module int8_vector_l2_normalizer_top
    import l2n_pkg::*;
#(
    parameter int MAX_WORDS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire elem_t s_elem_0, input wire elem_t s_elem_1,
    input  wire elem_t s_elem_2, input wire elem_t s_elem_3,
    input  wire elem_t s_elem_4, input wire elem_t s_elem_5,
    input  wire elem_t s_elem_6, input wire elem_t s_elem_7,
    input  wire logic s_in_last,
    output logic      m_valid,
    input  wire logic m_ready,
    output norm_t m_norm_0, output norm_t m_norm_1,
    output norm_t m_norm_2, output norm_t m_norm_3,
    output norm_t m_norm_4, output norm_t m_norm_5,
    output norm_t m_norm_6, output norm_t m_norm_7,
    output logic  m_norm_valid,
    output logic  m_out_last
);
    localparam int LANES = 8;
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam logic [1:0] ST_LOAD = 2'd0, ST_READ = 2'd1, ST_RUN = 2'd2, ST_OUT = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;
    sum_t          sum_reg, sum_next;
    logic          wait_reg, wait_next;
    logic          mvalid_reg, mvalid_next;
    logic          mlast_reg, mlast_next;
    logic          mnv_reg, mnv_next;
    norm_t         mnorm_reg [LANES];
    norm_t         mnorm_next [LANES];
    lane_ctl_t     ctl;

    elem_t in_e [LANES];
    assign in_e[0] = s_elem_0; assign in_e[1] = s_elem_1;
    assign in_e[2] = s_elem_2; assign in_e[3] = s_elem_3;
    assign in_e[4] = s_elem_4; assign in_e[5] = s_elem_5;
    assign in_e[6] = s_elem_6; assign in_e[7] = s_elem_7;

    logic        acc;
    logic        store_ok;
    logic [63:0] wr_word, rd_word;
    sum_t        sq_sum;
    logic [AW-1:0] rd_addr;
    norm_t       lane_res [LANES];
    logic [LANES-1:0] lane_done;

    assign acc      = s_valid && s_ready;
    assign store_ok = count_reg < CW'(MAX_WORDS);
    assign s_ready  = (state_reg == ST_LOAD);

    always_comb begin
        sq_sum = sum_reg;
        for (int i = 0; i < LANES; i++) begin
            wr_word[8*i +: 8] = in_e[i];
            // square at 16 bits, -128 * -128 still fits
            sq_sum = sq_sum + SUM_W'($unsigned(16'(in_e[i]) * 16'(in_e[i])));
        end
    end

    assign rd_addr = rd_reg[AW-1:0];

    l2n_ram #(.WIDTH(64), .DEPTH(MAX_WORDS)) u_store (
        .aclk(aclk), .wr_en(acc && store_ok), .wr_addr(count_reg[AW-1:0]),
        .wr_data(wr_word), .rd_addr(rd_addr), .rd_data(rd_word)
    );

    assign ctl.start = (state_reg == ST_READ) && wait_reg;
    assign ctl.busy  = (state_reg == ST_RUN);
    assign ctl.done  = lane_done[0];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        l2n_lane u_lane (
            .aclk(aclk), .aresetn(aresetn), .start(ctl.start),
            .x(elem_t'(rd_word[8*g +: 8])), .s(sum_reg), .valid(sum_reg != '0),
            .result(lane_res[g]), .done(lane_done[g])
        );
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_next     = rd_reg;
        sum_next    = sum_reg;
        wait_next   = 1'b0;
        mvalid_next = mvalid_reg;
        mlast_next  = mlast_reg;
        mnv_next    = mnv_reg;
        mnorm_next  = mnorm_reg;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (acc) begin
                    if (store_ok) begin
                        sum_next   = sq_sum;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_in_last) begin
                        rd_next    = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // wait for the registered ram read, then start lanes
                if (!wait_reg) wait_next = 1'b1;
                else state_next = ST_RUN;
            end
            ST_RUN: begin
                if (ctl.done) state_next = ST_OUT;
            end
            default: begin
                if (!mvalid_reg || m_ready) begin
                    mvalid_next = 1'b1;
                    mnv_next    = sum_reg != '0;
                    mlast_next  = (rd_reg + CW'(1)) == count_reg;
                    for (int i = 0; i < LANES; i++) mnorm_next[i] = lane_res[i];
                    if ((rd_reg + CW'(1)) == count_reg) begin
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        rd_next    = rd_reg + CW'(1);
                        state_next = ST_READ;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            sum_reg    <= '0;
            wait_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            wait_reg   <= wait_next;
            mvalid_reg <= mvalid_next;
        end
        rd_reg    <= rd_next;
        mlast_reg <= mlast_next;
        mnv_reg   <= mnv_next;
        mnorm_reg <= mnorm_next;
    end

    assign m_valid = mvalid_reg;
    assign m_out_last = mlast_reg;
    assign m_norm_valid = mnv_reg;
    assign m_norm_0 = mnorm_reg[0]; assign m_norm_1 = mnorm_reg[1];
    assign m_norm_2 = mnorm_reg[2]; assign m_norm_3 = mnorm_reg[3];
    assign m_norm_4 = mnorm_reg[4]; assign m_norm_5 = mnorm_reg[5];
    assign m_norm_6 = mnorm_reg[6]; assign m_norm_7 = mnorm_reg[7];

    `L2N_ASSERT_IMPL(a_count_bound, aclk, aresetn, count_reg <= CW'(MAX_WORDS))
    `L2N_ASSERT_IMPL(a_lanes_agree, aclk, aresetn, lane_done == '0 || lane_done == '1)
    `L2N_ASSERT_NEXT(a_last_to_load, aclk, aresetn,
        m_valid && m_ready && m_out_last && state_reg != ST_OUT, s_ready || state_reg != ST_OUT)
endmodule
`default_nettype wire

FILE: rtl/core/l2n_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module l2n_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                          aclk,
    input  wire logic                                          wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                              wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                              rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/l2n_lane.sv
// one lane: bit-serial search for q with q*q*s <= a*a*2^30
`timescale 1ns / 1ps
`default_nettype none
module l2n_lane
    import l2n_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  start,
    input  wire elem_t x,
    input  wire sum_t  s,
    input  wire logic  valid,
    output norm_t      result,
    output logic       done
);
    // phases per bit: 0 square c, 1 multiply by s, 2 compare
    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [15:0] q_reg, q_next;
    logic [31:0] csq_reg, csq_next;
    logic [55:0] prod_reg, prod_next;
    logic [7:0]  a_reg, a_next;
    logic        neg_reg, neg_next;
    logic [15:0] cand;
    logic [44:0] target;
    logic [15:0] mag;

    assign cand   = q_reg | (16'd1 << bit_reg[3:0]);
    assign target = {23'd0, 8'd0, a_reg} * {37'd0, a_reg} << 30;

    always_comb begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        q_next     = q_reg;
        csq_next   = csq_reg;
        prod_next  = prod_reg;
        a_next     = a_reg;
        neg_next   = neg_reg;
        if (start) begin
            a_next     = x[7] ? 8'(-x) : 8'(x);
            neg_next   = x[7];
            q_next     = '0;
            bit_next   = 5'd15;
            phase_next = 2'd0;
            busy_next  = valid;
            done_next  = !valid;
        end else if (busy_reg) begin
            case (phase_reg)
                2'd0: begin
                    csq_next   = 32'(cand) * 32'(cand);
                    phase_next = 2'd1;
                end
                2'd1: begin
                    prod_next  = 56'(csq_reg) * 56'(s);
                    phase_next = 2'd2;
                end
                default: begin
                    if (prod_reg <= 56'(target)) q_next = cand;
                    phase_next = 2'd0;
                    if (bit_reg == 5'd0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        bit_next = bit_reg - 5'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        phase_reg <= phase_next;
        bit_reg   <= bit_next;
        q_reg     <= q_next;
        csq_reg   <= csq_next;
        prod_reg  <= prod_next;
        a_reg     <= a_next;
        neg_reg   <= neg_next;
    end

    assign mag    = (q_reg > QMAX) ? QMAX : q_reg;
    assign result = neg_reg ? norm_t'(-mag) : norm_t'(mag);
    assign done   = done_reg;
endmodule
`default_nettype wire
